// ----- rtl/ulc_pkg.sv -----
// shared types and constants for the serial line command and led control block
// no dependencies; imported by every module of the block but the queue
`default_nettype none

package ulc_pkg;

  // input command codes
  localparam logic [1:0] CMD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // special characters
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7e;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5a;

  // blink period after reset
  localparam logic [15:0] BLINK_PERIOD_RESET = 16'd500;

  // command words, lower case, first char in entry 0, 7-bit chars
  localparam int MATCH_CHARS = 5;
  localparam logic [4:0][6:0] WORD_HELP  = {7'h00, 7'h70, 7'h6c, 7'h65, 7'h68};
  localparam logic [4:0][6:0] WORD_ON    = {7'h00, 7'h00, 7'h00, 7'h6e, 7'h6f};
  localparam logic [4:0][6:0] WORD_OFF   = {7'h00, 7'h00, 7'h66, 7'h66, 7'h6f};
  localparam logic [4:0][6:0] WORD_BLINK = {7'h6b, 7'h6e, 7'h69, 7'h6c, 7'h62};
  localparam logic [4:0][6:0] WORD_RESET = {7'h74, 7'h65, 7'h73, 7'h65, 7'h72};

  // reported command codes
  typedef enum logic [2:0] {
    CODE_NONE    = 3'd0,
    CODE_HELP    = 3'd1,
    CODE_ON      = 3'd2,
    CODE_OFF     = 3'd3,
    CODE_BLINK   = 3'd4,
    CODE_RESET   = 3'd5,
    CODE_UNKNOWN = 3'd6
  } code_t;

  // what the back end has to send for one input
  typedef enum logic [2:0] {
    JOB_NONE,
    JOB_ECHO,
    JOB_ERASE,
    JOB_CRLF,
    JOB_FULL
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] data;
    code_t      code;
    logic       led;
  } job_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic [2:0] command_code;
    logic       led_level;
    logic       last;
  } out_t;

  // buffer full message, sixteen bytes
  function automatic logic [7:0] full_msg_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = CH_CR;
      4'd1:    b = CH_LF;
      4'd2:    b = 8'h42;
      4'd3:    b = 8'h75;
      4'd4:    b = 8'h66;
      4'd5:    b = 8'h66;
      4'd6:    b = 8'h65;
      4'd7:    b = 8'h72;
      4'd8:    b = CH_SPACE;
      4'd9:    b = 8'h66;
      4'd10:   b = 8'h75;
      4'd11:   b = 8'h6c;
      4'd12:   b = 8'h6c;
      4'd13:   b = 8'h21;
      4'd14:   b = CH_CR;
      default: b = CH_LF;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ulc_queue.sv -----
// small word queue in flip-flops between front and back end
// generic over width and depth; no package needed
`default_nettype none

module ulc_queue #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ulc_front.sv -----
// front end: line editor, command match, led and blink state, one input per cycle
// while the queue has room; uses ulc_pkg; one job word per input to the queue
`default_nettype none

module ulc_front #(
  parameter int LINE_CAPACITY = 127,
  parameter int KEY_CHARS     = 5
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ulc_pkg::in_t  in_data,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [15:0]   cfg_data,
  output logic               job_valid,
  input  wire logic          job_ready,
  output ulc_pkg::job_t      job
);
  import ulc_pkg::*;

  localparam int LL_W = $clog2(LINE_CAPACITY + 1);
  localparam int KI_W = $clog2(KEY_CHARS);

  logic [LL_W-1:0]  line_length, line_length_next;
  logic [6:0]       keys [KEY_CHARS];
  logic             led_on, led_on_next;
  logic             blink_mode, blink_mode_next;
  logic [15:0]      elapsed, elapsed_next;
  logic [15:0]      elapsed_inc;
  logic [15:0]      blink_period;
  logic             key_we;
  logic [6:0]       key_wdata;
  logic [4:0][6:0]  key5;
  code_t            code;
  logic             accept;
  logic [7:0]       c;

  assign in_ready  = job_ready;
  assign job_valid = in_valid;
  assign accept    = in_valid && job_ready;
  assign cfg_ready = 1'b1;
  assign c         = in_data.rx_byte;

  // first chars of the line as seen by the matcher
  always_comb begin
    for (int i = 0; i < MATCH_CHARS; i++) begin
      key5[i] = keys[i];
    end
  end

  function automatic logic word_is(input logic [4:0][6:0] k, input logic [LL_W-1:0] len,
                                   input logic [4:0][6:0] w, input int wlen);
    logic hit;
    hit = (len == LL_W'(wlen));
    for (int i = 0; i < MATCH_CHARS; i++) begin
      if (i < wlen && k[i] != w[i]) begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

  // line classification
  always_comb begin
    if (word_is(key5, line_length, WORD_HELP, 4)) begin
      code = CODE_HELP;
    end else if (word_is(key5, line_length, WORD_ON, 2)) begin
      code = CODE_ON;
    end else if (word_is(key5, line_length, WORD_OFF, 3)) begin
      code = CODE_OFF;
    end else if (word_is(key5, line_length, WORD_BLINK, 5)) begin
      code = CODE_BLINK;
    end else if (word_is(key5, line_length, WORD_RESET, 5)) begin
      code = CODE_RESET;
    end else begin
      code = CODE_UNKNOWN;
    end
  end

  assign elapsed_inc = (elapsed != 16'hffff) ? elapsed + 16'd1 : elapsed;

  // next state and job word
  always_comb begin
    line_length_next = line_length;
    led_on_next      = led_on;
    blink_mode_next  = blink_mode;
    elapsed_next     = elapsed;
    key_we           = 1'b0;
    key_wdata        = (c >= CH_UP_A && c <= CH_UP_Z) ? c[6:0] + 7'h20 : c[6:0];
    job.kind         = JOB_NONE;
    job.data         = c;
    job.code         = CODE_NONE;
    unique case (in_data.command)
      CMD_BYTE: begin
        if (c == CH_CR || c == CH_LF) begin
          if (line_length != '0) begin
            job.kind         = JOB_CRLF;
            job.code         = code;
            line_length_next = '0;
            if (code == CODE_ON) begin
              led_on_next     = 1'b1;
              blink_mode_next = 1'b0;
            end else if (code == CODE_OFF) begin
              led_on_next     = 1'b0;
              blink_mode_next = 1'b0;
            end else if (code == CODE_BLINK) begin
              led_on_next     = 1'b0;
              blink_mode_next = 1'b1;
              elapsed_next    = '0;
            end
          end
        end else if (c == CH_BS || c == CH_DEL) begin
          if (line_length != '0) begin
            job.kind         = JOB_ERASE;
            line_length_next = line_length - 1'b1;
          end
        end else if (c >= CH_SPACE && c <= CH_TILDE) begin
          if (line_length < LL_W'(LINE_CAPACITY)) begin
            job.kind         = JOB_ECHO;
            key_we           = (line_length < LL_W'(KEY_CHARS));
            line_length_next = line_length + 1'b1;
          end else begin
            job.kind         = JOB_FULL;
            line_length_next = '0;
          end
        end
      end
      CMD_TICK: begin
        if (blink_mode) begin
          if (elapsed_inc >= blink_period) begin
            led_on_next  = !led_on;
            elapsed_next = '0;
          end else begin
            elapsed_next = elapsed_inc;
          end
        end
      end
      CMD_CLEAR: begin
        line_length_next = '0;
      end
      default: begin
      end
    endcase
    job.led = led_on_next;
  end

  // stored key characters
  always_ff @(posedge clk) begin
    if (accept && key_we) begin
      keys[line_length[KI_W-1:0]] <= key_wdata;
    end
  end

  // editor and led state
  always_ff @(posedge clk) begin
    if (rst) begin
      line_length  <= '0;
      led_on       <= 1'b0;
      blink_mode   <= 1'b0;
      elapsed      <= '0;
      blink_period <= BLINK_PERIOD_RESET;
    end else begin
      if (cfg_valid) begin
        blink_period <= cfg_data;
      end
      if (accept) begin
        line_length <= line_length_next;
        led_on      <= led_on_next;
        blink_mode  <= blink_mode_next;
        elapsed     <= elapsed_next;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ulc_back.sv -----
// back end: expands one job word into its result words, one per cycle
// unless stalled; uses ulc_pkg; drives the registered output channel
`default_nettype none

module ulc_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           job_valid,
  output logic                job_ready,
  input  wire ulc_pkg::job_t  job,
  output logic                out_valid,
  input  wire logic           out_ready,
  output ulc_pkg::out_t       out_data
);
  import ulc_pkg::*;

  logic [3:0] step;
  logic [3:0] last_step;
  logic       load;
  out_t       item;

  // number of words for this job, less one
  always_comb begin
    case (job.kind)
      JOB_ERASE: last_step = 4'd2;
      JOB_CRLF:  last_step = 4'd1;
      JOB_FULL:  last_step = 4'd15;
      default:   last_step = 4'd0;
    endcase
  end

  // word for the current step
  always_comb begin
    item.tx_byte      = 8'h00;
    item.tx_valid     = 1'b1;
    item.command_code = CODE_NONE;
    item.led_level    = job.led;
    item.last         = (step == last_step);
    case (job.kind)
      JOB_ECHO:  item.tx_byte = job.data;
      JOB_ERASE: item.tx_byte = (step == 4'd1) ? CH_SPACE : CH_BS;
      JOB_CRLF: begin
        item.tx_byte      = (step == 4'd0) ? CH_CR : CH_LF;
        item.command_code = job.code;
      end
      JOB_FULL:  item.tx_byte = full_msg_byte(step);
      default:   item.tx_valid = 1'b0;
    endcase
  end

  assign load      = job_valid && (!out_valid || out_ready);
  assign job_ready = load && (step == last_step);

  // output register and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        step      <= (step == last_step) ? 4'd0 : step + 4'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= item;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/uart_line_command_led_control_core.sv -----
// path: job queue, then the back end output register for each result word
// input: one word per cycle while the four-entry job queue has room
// output: one result word per cycle while out_ready is high, from the back end
//   sequencer, 1 to 16 words per input (sixteen for buffer full), which sets the rate
// reset: synchronous; clears line, led, blink state, tick count, queue; period 500
`default_nettype none

module uart_line_command_led_control_core #(
  parameter int LINE_CAPACITY = 127,
  parameter int KEY_CHARS     = 5
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ulc_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ulc_pkg::out_t      out_data,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [15:0]   cfg_data
);
  import ulc_pkg::*;

  localparam int JOB_W = $bits(job_t);

  logic             push_valid, push_ready;
  logic             pop_valid, pop_ready;
  job_t             push_job, pop_job;
  logic [JOB_W-1:0] pop_bits;

  // line editor and state
  ulc_front #(
    .LINE_CAPACITY (LINE_CAPACITY),
    .KEY_CHARS     (KEY_CHARS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .job_valid (push_valid),
    .job_ready (push_ready),
    .job       (push_job)
  );

  // job queue
  ulc_queue #(
    .WIDTH (JOB_W),
    .DEPTH (4)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_bits)
  );

  assign pop_job = job_t'(pop_bits);

  // result sequencer
  ulc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (pop_valid),
    .job_ready (pop_ready),
    .job       (pop_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- rtl/ulc_checker.sv -----
// port level checks for the serial line command and led control block
// uses ulc_pkg; bound to uart_line_command_led_control_core
`default_nettype none

module ulc_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire ulc_pkg::in_t  in_data,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire ulc_pkg::out_t out_data
);
  import ulc_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // offered input word holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input word changed while waiting");

  // a word with nothing to send is alone and carries no code
  a_empty_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.tx_valid |-> out_data.last && out_data.command_code == CODE_NONE)
    else $error("empty word not a lone final word");

  // command codes ride only on the line ending
  a_code_on_crlf: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.command_code != CODE_NONE |->
      out_data.tx_valid && (out_data.tx_byte == CH_CR || out_data.tx_byte == CH_LF))
    else $error("command code outside line ending");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid after reset");

endmodule

bind uart_line_command_led_control_core ulc_checker u_ulc_checker (.*);

`default_nettype wire
